FILE: rtl/core/pulse_over_threshold_finder_defines.svh
// ----------------------------------------------------------------------------
// Pulse-over-threshold finder assertion macros
// Concurrent property shorthands clocked on clk_i, disabled while rst_ni low.
// ----------------------------------------------------------------------------
`ifndef PULSE_OVER_THRESHOLD_FINDER_DEFINES_SVH
`define PULSE_OVER_THRESHOLD_FINDER_DEFINES_SVH

// same-cycle implication
`define POTF_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("pot_checker: property violated");

// next-cycle implication
`define POTF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pot_checker: property violated");

`endif

FILE: rtl/core/pot_pkg.sv
// ----------------------------------------------------------------------------
// Pulse-over-threshold finder package
// Sizes, register indexes and the spread-test request/result types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pot_pkg;

  localparam int MAX_PULSE   = 64;
  localparam int MAX_TRACE   = 4096;
  localparam int SAMPLE_W    = 16;

  localparam int LEN_W       = $clog2(MAX_PULSE + 1);
  localparam int IDX_W       = $clog2(MAX_PULSE);
  localparam int POS_W       = 12;
  localparam int TPOS_W      = $clog2(MAX_TRACE) + 1;
  localparam int TNX_W       = TPOS_W + 1;
  localparam int DIFF_W      = SAMPLE_W + 1;
  localparam int SQS_W       = 2 * SAMPLE_W;
  localparam int SUM_W       = 22;
  localparam int SQ_W        = 38;

  localparam int THR_W       = 15;
  localparam int FLAT_W      = 7;
  localparam int MINLEN_W    = 7;
  localparam int LIMIT_W     = 32;
  localparam int WSTART_W    = 12;
  localparam int WSTOP_W     = 13;

  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_THRESHOLD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FLAT_RUN_LIMIT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MINIMUM_LENGTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPREAD_LIMIT_SQ = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_START    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_STOP     = 3'd5;

  typedef struct packed {
    logic                    start;
    logic [LEN_W-1:0]        len;
    logic signed [SUM_W-1:0] sum;
    logic [SQ_W-1:0]         sumsq;
  } spread_req_t;

  typedef struct packed {
    logic done;
    logic keep;
  } spread_res_t;

endpackage

FILE: rtl/core/pulse_over_threshold_finder.sv
// ----------------------------------------------------------------------------
// Pulse-over-threshold finder
// One sample per cycle while no run closes. A closing sample holds the input
// stalled through the spread test and any read-out; a kept run of n points
// then reads out of the pulse store one point per cycle unless the output
// stalls. Reset is asynchronous active low: registers return to their
// defaults, the pulse store is not cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pulse_over_threshold_finder (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [pot_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [pot_pkg::CFG_DATA_W-1:0]       cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic signed [pot_pkg::SAMPLE_W-1:0]  sample_i,
  input  logic                                 end_of_trace_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [pot_pkg::POS_W-1:0]            position_o,
  output logic signed [pot_pkg::SAMPLE_W-1:0]  value_o,
  output logic                                 last_in_pulse_o
);

  localparam logic [1:0] ST_RUN  = 2'd0;
  localparam logic [1:0] ST_EVAL = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  localparam int SAMPLE_W = pot_pkg::SAMPLE_W;
  localparam int LEN_W    = pot_pkg::LEN_W;
  localparam int IDX_W    = pot_pkg::IDX_W;
  localparam int POS_W    = pot_pkg::POS_W;
  localparam int TPOS_W   = pot_pkg::TPOS_W;
  localparam int TNX_W    = pot_pkg::TNX_W;
  localparam int DIFF_W   = pot_pkg::DIFF_W;
  localparam int SQS_W    = pot_pkg::SQS_W;
  localparam int SUM_W    = pot_pkg::SUM_W;
  localparam int SQ_W     = pot_pkg::SQ_W;
  localparam int FLAT_W   = pot_pkg::FLAT_W;

  // configuration
  logic [pot_pkg::THR_W-1:0]     thr_q;
  logic [FLAT_W-1:0]             flat_lim_q;
  logic [pot_pkg::MINLEN_W-1:0]  min_len_q;
  logic [pot_pkg::LIMIT_W-1:0]   limit_q;
  logic [pot_pkg::WSTART_W-1:0]  win_start_q;
  logic [pot_pkg::WSTOP_W-1:0]   win_stop_q;

  // run state
  logic [1:0]                state_q, state_d;
  logic                      in_pulse_q, in_pulse_d;
  logic [LEN_W-1:0]          len_q, len_d;
  logic [FLAT_W-1:0]         flat_q, flat_d;
  logic signed [SUM_W-1:0]   sum_q, sum_d;
  logic [SQ_W-1:0]           sq_q, sq_d;
  logic [POS_W-1:0]          org_q, org_d;
  logic signed [SAMPLE_W-1:0] prior_q, prior_d;
  logic [TPOS_W-1:0]         pos_q, pos_d;
  logic                      eval_go_q, eval_go_d;
  logic [LEN_W-1:0]          iss_q, iss_d;

  // pulse store and read-out stages
  logic signed [SAMPLE_W-1:0] mem_q [pot_pkg::MAX_PULSE];
  logic                      wr_en;
  logic [IDX_W-1:0]          wr_idx;
  logic                      rd_issue, a_adv;
  logic                      rd_vld_q;
  logic signed [SAMPLE_W-1:0] rd_val_q;
  logic [POS_W-1:0]          rd_pos_q;
  logic                      rd_last_q;
  logic                      out_valid_q;
  logic signed [SAMPLE_W-1:0] out_val_q;
  logic [POS_W-1:0]          out_pos_q;
  logic                      out_last_q;

  // sample datapath
  logic                      in_acc;
  logic                      in_win, last_win, above, diff_big, flat_ok, full;
  logic [TNX_W-1:0]          pos_nx;
  logic signed [DIFF_W-1:0]  s_ext, p_ext, diff;
  logic [DIFF_W-1:0]         diff_abs;
  logic [FLAT_W-1:0]         flat_nx;
  logic signed [SQS_W-1:0]   s_sq_ext;
  logic [SQS_W-1:0]          sq_samp;
  logic signed [SUM_W-1:0]   s_sum;
  logic [LEN_W-1:0]          len_app;
  logic                      close;

  pot_pkg::spread_req_t      sp_req;
  pot_pkg::spread_res_t      sp_res;

  assign in_acc = in_valid_i && (state_q == ST_RUN);

  assign pos_nx  = {1'b0, pos_q} + TNX_W'(1);
  assign in_win  = (pos_q >= TPOS_W'(win_start_q)) &&
                   (pos_q < TPOS_W'(pot_pkg::MAX_TRACE)) &&
                   ((win_stop_q == '0) || (pos_q < TPOS_W'(win_stop_q)));
  assign last_win = end_of_trace_i ||
                    (pos_nx >= TNX_W'(pot_pkg::MAX_TRACE)) ||
                    ((win_stop_q != '0) && (pos_nx >= TNX_W'(win_stop_q)));

  assign s_ext    = {sample_i[SAMPLE_W-1], sample_i};
  assign p_ext    = {prior_q[SAMPLE_W-1], prior_q};
  assign above    = s_ext > $signed(DIFF_W'(thr_q));
  assign diff     = s_ext - p_ext;
  assign diff_abs = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
  assign diff_big = diff_abs > DIFF_W'(thr_q);
  assign flat_nx  = diff_big ? '0 : flat_q + FLAT_W'(1);
  assign flat_ok  = flat_nx < flat_lim_q;

  assign s_sq_ext = {{(SQS_W - SAMPLE_W){sample_i[SAMPLE_W-1]}}, sample_i};
  assign sq_samp  = s_sq_ext * s_sq_ext;
  assign s_sum    = {{(SUM_W - SAMPLE_W){sample_i[SAMPLE_W-1]}}, sample_i};
  assign len_app  = len_q + LEN_W'(1);
  assign full     = len_app == LEN_W'(pot_pkg::MAX_PULSE);

  assign a_adv    = rd_vld_q && (!out_valid_q || !out_stall_i);
  assign rd_issue = (state_q == ST_EMIT) && (iss_q != len_q) && (!rd_vld_q || a_adv);

  always_comb begin
    state_d    = state_q;
    in_pulse_d = in_pulse_q;
    len_d      = len_q;
    flat_d     = flat_q;
    sum_d      = sum_q;
    sq_d       = sq_q;
    org_d      = org_q;
    prior_d    = prior_q;
    pos_d      = pos_q;
    eval_go_d  = 1'b0;
    iss_d      = iss_q;
    wr_en      = 1'b0;
    wr_idx     = len_q[IDX_W-1:0];
    close      = 1'b0;
    case (state_q)
      ST_RUN: begin
        if (in_acc) begin
          prior_d = sample_i;
          if (end_of_trace_i) begin
            pos_d = '0;
          end else if (pos_q < TPOS_W'(pot_pkg::MAX_TRACE)) begin
            pos_d = pos_q + TPOS_W'(1);
          end
          if (in_pulse_q) begin
            if (!in_win || !above || !flat_ok) begin
              close = 1'b1;
            end else begin
              wr_en  = 1'b1;
              len_d  = len_app;
              sum_d  = sum_q + s_sum;
              sq_d   = sq_q + SQ_W'(sq_samp);
              flat_d = flat_nx;
              close  = full || last_win;
            end
          end else if (in_win && above) begin
            in_pulse_d = 1'b1;
            org_d      = pos_q[POS_W-1:0];
            wr_en      = 1'b1;
            wr_idx     = '0;
            len_d      = LEN_W'(1);
            sum_d      = s_sum;
            sq_d       = SQ_W'(sq_samp);
            flat_d     = '0;
            close      = last_win;
          end
          if (close) begin
            in_pulse_d = 1'b0;
            flat_d     = '0;
            eval_go_d  = 1'b1;
            state_d    = ST_EVAL;
          end
        end
      end
      ST_EVAL: begin
        if (sp_res.done) begin
          if (sp_res.keep) begin
            iss_d   = '0;
            state_d = ST_EMIT;
          end else begin
            state_d = ST_RUN;
          end
        end
      end
      ST_EMIT: begin
        if (rd_issue) begin
          iss_d = iss_q + LEN_W'(1);
        end
        if ((iss_q == len_q) && !rd_vld_q) begin
          state_d = ST_RUN;
        end
      end
      default: state_d = ST_RUN;
    endcase
  end

  assign sp_req.start = eval_go_q;
  assign sp_req.len   = len_q;
  assign sp_req.sum   = sum_q;
  assign sp_req.sumsq = sq_q;

  pot_spread u_spread (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (sp_req),
    .min_len_i (min_len_q),
    .limit_i   (limit_q),
    .res_o     (sp_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q       <= '0;
      flat_lim_q  <= FLAT_W'(64);
      min_len_q   <= pot_pkg::MINLEN_W'(1);
      limit_q     <= '0;
      win_start_q <= '0;
      win_stop_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        pot_pkg::CFG_LEVEL_THRESHOLD: thr_q       <= cfg_data_i[pot_pkg::THR_W-1:0];
        pot_pkg::CFG_FLAT_RUN_LIMIT:  flat_lim_q  <= cfg_data_i[FLAT_W-1:0];
        pot_pkg::CFG_MINIMUM_LENGTH:  min_len_q   <= cfg_data_i[pot_pkg::MINLEN_W-1:0];
        pot_pkg::CFG_SPREAD_LIMIT_SQ: limit_q     <= cfg_data_i[pot_pkg::LIMIT_W-1:0];
        pot_pkg::CFG_WINDOW_START:    win_start_q <= cfg_data_i[pot_pkg::WSTART_W-1:0];
        pot_pkg::CFG_WINDOW_STOP:     win_stop_q  <= cfg_data_i[pot_pkg::WSTOP_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_RUN;
      in_pulse_q  <= 1'b0;
      len_q       <= '0;
      flat_q      <= '0;
      sum_q       <= '0;
      sq_q        <= '0;
      org_q       <= '0;
      prior_q     <= '0;
      pos_q       <= '0;
      eval_go_q   <= 1'b0;
      iss_q       <= '0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      in_pulse_q <= in_pulse_d;
      len_q      <= len_d;
      flat_q     <= flat_d;
      sum_q      <= sum_d;
      sq_q       <= sq_d;
      org_q      <= org_d;
      prior_q    <= prior_d;
      pos_q      <= pos_d;
      eval_go_q  <= eval_go_d;
      iss_q      <= iss_d;
      if (rd_issue) begin
        rd_vld_q <= 1'b1;
      end else if (a_adv) begin
        rd_vld_q <= 1'b0;
      end
      if (a_adv) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // pulse store: write on append, registered read during read-out
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_idx] <= sample_i;
    end
    if (rd_issue) begin
      rd_val_q  <= mem_q[iss_q[IDX_W-1:0]];
      rd_pos_q  <= org_q + POS_W'(iss_q);
      rd_last_q <= (iss_q + LEN_W'(1)) == len_q;
    end
    if (a_adv) begin
      out_val_q  <= rd_val_q;
      out_pos_q  <= rd_pos_q;
      out_last_q <= rd_last_q;
    end
  end

  assign in_stall_o      = state_q != ST_RUN;
  assign out_valid_o     = out_valid_q;
  assign position_o      = out_pos_q;
  assign value_o         = out_val_q;
  assign last_in_pulse_o = out_last_q;

endmodule

FILE: rtl/core/pot_spread.sv
// ----------------------------------------------------------------------------
// Pulse spread test
// Three-stage pipeline: n*sumsq - sum^2 > n^2*limit with minimum-length gate.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pot_spread (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  pot_pkg::spread_req_t               req_i,
  input  logic [pot_pkg::MINLEN_W-1:0]       min_len_i,
  input  logic [pot_pkg::LIMIT_W-1:0]        limit_i,
  output pot_pkg::spread_res_t               res_o
);

  localparam int NSQ_W   = pot_pkg::LEN_W + pot_pkg::SQ_W;
  localparam int SS_W    = 2 * pot_pkg::SUM_W;
  localparam int NN_W    = 2 * pot_pkg::LEN_W;
  localparam int BOUND_W = NN_W + pot_pkg::LIMIT_W;
  localparam int CMP_W   = BOUND_W + 1;

  logic                     v1_q, v2_q, done_q;
  logic                     min1_q, min2_q, keep_q;
  logic [NSQ_W-1:0]         nsq_q;
  logic [SS_W-1:0]          ss_q;
  logic [NN_W-1:0]          nn_q;
  logic signed [CMP_W-1:0]  spread_q;
  logic [BOUND_W-1:0]       bound_q;

  logic signed [SS_W-1:0]   sum_ext;
  logic [NSQ_W-1:0]         nsq_d;
  logic [SS_W-1:0]          ss_d;
  logic [NN_W-1:0]          nn_d;
  logic                     min_d;
  logic signed [CMP_W-1:0]  spread_d;
  logic [BOUND_W-1:0]       bound_d;
  logic                     keep_d;

  assign sum_ext  = {{(SS_W - pot_pkg::SUM_W){req_i.sum[pot_pkg::SUM_W-1]}}, req_i.sum};
  assign nsq_d    = NSQ_W'(req_i.len) * NSQ_W'(req_i.sumsq);
  assign ss_d     = sum_ext * sum_ext;
  assign nn_d     = NN_W'(req_i.len) * NN_W'(req_i.len);
  assign min_d    = (req_i.len != '0) && (req_i.len >= pot_pkg::LEN_W'(min_len_i));

  assign spread_d = $signed(CMP_W'(nsq_q)) - $signed(CMP_W'(ss_q));
  assign bound_d  = BOUND_W'(nn_q) * BOUND_W'(limit_i);

  assign keep_d   = min2_q && (spread_q > $signed(CMP_W'(bound_q)));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      v1_q   <= req_i.start;
      v2_q   <= v1_q;
      done_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    nsq_q    <= nsq_d;
    ss_q     <= ss_d;
    nn_q     <= nn_d;
    min1_q   <= min_d;
    spread_q <= spread_d;
    bound_q  <= bound_d;
    min2_q   <= min1_q;
    keep_q   <= keep_d;
  end

  assign res_o.done = done_q;
  assign res_o.keep = keep_q;

endmodule

FILE: rtl/core/pot_checker.sv
// ----------------------------------------------------------------------------
// Pulse-over-threshold finder port checker
// Watches the top-level ports for read-out ordering and handshake hold.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "pulse_over_threshold_finder_defines.svh"

module pot_checker (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 in_stall_o,
  input logic                                 out_valid_o,
  input logic                                 out_stall_i,
  input logic [pot_pkg::POS_W-1:0]            position_o,
  input logic signed [pot_pkg::SAMPLE_W-1:0]  value_o,
  input logic                                 last_in_pulse_o
);

  // hold a stalled output beat
  `POTF_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(position_o) && $stable(value_o) && $stable(last_in_pulse_o))

  // input stays stalled while a pulse is still being read out
  `POTF_ASSERT_NOW(a_stall_mid_pulse, out_valid_o && !last_in_pulse_o, in_stall_o)

  // first beat after an idle output belongs to a read-out
  `POTF_ASSERT_NOW(a_stall_on_start, $rose(out_valid_o), in_stall_o)

  // advance position by one between beats of one pulse
  `POTF_ASSERT_NEXT(a_pos_step, out_valid_o && !out_stall_i && !last_in_pulse_o, !out_valid_o || (position_o == ($past(position_o) + 1'b1)))

endmodule

bind pulse_over_threshold_finder pot_checker u_pot_checker (.*);
